FILE: sv/pstrr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Slot table package
// Shared types and constants of the task slot table and its scheduler.
// ----------------------------------------------------------------------------
package pstrr_pkg;

    // Width of every slot number on the ports.
    localparam int SLOT_W = 6;

    // Default number of task slots.
    localparam int SLOTS_DEFAULT = 8;

    // Depth of the request queue between front and back.
    localparam int QUEUE_DEPTH = 2;

    localparam logic [1:0] ST_UNUSED     = 2'd0;
    localparam logic [1:0] ST_RUNNABLE   = 2'd1;
    localparam logic [1:0] ST_TERMINATED = 2'd2;

    localparam logic [2:0] CMD_CREATE   = 3'd0;
    localparam logic [2:0] CMD_EXIT     = 3'd1;
    localparam logic [2:0] CMD_SET      = 3'd2;
    localparam logic [2:0] CMD_SCHEDULE = 3'd3;
    localparam logic [2:0] CMD_LOOKUP   = 3'd4;

    typedef enum logic [2:0] {
        OP_CREATE,
        OP_EXIT,
        OP_SET,
        OP_SCHEDULE,
        OP_LOOKUP,
        OP_NONE
    } op_t;

    // One classified request as it travels from front to back.
    typedef struct packed {
        op_t                op;
        logic               in_range;
        logic [SLOT_W-1:0]  slot;
        logic [1:0]         new_status;
        logic [SLOT_W-1:0]  start;
    } req_t;

endpackage

FILE: sv/pstrr_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Slot table front end
// Decodes a command, checks the target slot and works out where the
// round-robin scan starts.
// ----------------------------------------------------------------------------
module pstrr_front #(
    parameter int SLOTS = pstrr_pkg::SLOTS_DEFAULT
) (
    input  logic [2:0]                  command,
    input  logic [pstrr_pkg::SLOT_W-1:0] slot,
    input  logic [1:0]                  new_status,
    input  logic [pstrr_pkg::SLOT_W-1:0] current_slot,
    output pstrr_pkg::req_t             req
);

    localparam int NEXT_W = pstrr_pkg::SLOT_W + 1;

    logic [NEXT_W-1:0]             next_slot;
    logic [pstrr_pkg::SLOT_W-1:0]  start;
    pstrr_pkg::op_t                op;

    assign next_slot = {1'b0, current_slot} + NEXT_W'(1);

    // The scan start (current_slot + 1) mod SLOTS, as a small constant table.
    always_comb
    begin
        start = '0;
        for (int k = 0; k < (1 << NEXT_W); k++)
        begin
            if (next_slot == NEXT_W'(k))
            begin
                start = pstrr_pkg::SLOT_W'(k % SLOTS);
            end
        end
    end

    always_comb
    begin
        unique case (command)
            pstrr_pkg::CMD_CREATE:   op = pstrr_pkg::OP_CREATE;
            pstrr_pkg::CMD_EXIT:     op = pstrr_pkg::OP_EXIT;
            pstrr_pkg::CMD_SET:      op = pstrr_pkg::OP_SET;
            pstrr_pkg::CMD_SCHEDULE: op = pstrr_pkg::OP_SCHEDULE;
            pstrr_pkg::CMD_LOOKUP:   op = pstrr_pkg::OP_LOOKUP;
            default:                 op = pstrr_pkg::OP_NONE;
        endcase
    end

    assign req.op         = op;
    assign req.in_range   = ({1'b0, slot} < NEXT_W'(SLOTS));
    assign req.slot       = slot;
    assign req.new_status = new_status;
    assign req.start      = start;

endmodule

FILE: sv/pstrr_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Slot table request queue
// A short first-in first-out queue of classified requests between the
// front end and the execution back end.
// ----------------------------------------------------------------------------
module pstrr_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            wr_en,
    input  pstrr_pkg::req_t wr_data,
    output logic            is_full,
    input  logic            rd_en,
    output logic            rd_valid,
    output pstrr_pkg::req_t rd_data
);

    localparam int DEPTH = pstrr_pkg::QUEUE_DEPTH;
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    pstrr_pkg::req_t   entry_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg;
    logic [PTR_W-1:0]  wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg;
    logic [PTR_W-1:0]  rd_ptr_next;
    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;
    logic              do_wr;
    logic              do_rd;

    assign is_full  = (count_reg == CNT_W'(DEPTH));
    assign rd_valid = (count_reg != '0);
    assign rd_data  = entry_reg[rd_ptr_reg];
    assign do_wr    = wr_en && !is_full;
    assign do_rd    = rd_en && rd_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        count_next = count_reg + CNT_W'(do_wr) - CNT_W'(do_rd);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            entry_reg[wr_ptr_reg] <= wr_data;
        end
    end

`ifndef ASSERT_OFF
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("request queue count exceeds its depth");
`endif

endmodule

FILE: sv/pstrr_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Slot table back end
// Holds the slot status table, carries out one request at a time and keeps
// the result in an output register until it is taken.
// ----------------------------------------------------------------------------
module pstrr_back #(
    parameter int SLOTS = pstrr_pkg::SLOTS_DEFAULT
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         req_valid,
    input  pstrr_pkg::req_t              req_data,
    output logic                         req_take,
    output logic                         out_valid,
    input  logic                         out_pop,
    output logic                         out_success,
    output logic [pstrr_pkg::SLOT_W-1:0] out_index,
    output logic                         out_idle
);

    localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int SW    = pstrr_pkg::SLOT_W;

    typedef enum logic {
        S_WAIT,
        S_EVAL
    } state_t;

    state_t               state_reg;
    state_t               state_next;
    logic [1:0]           status_reg [SLOTS];
    logic [1:0]           status_next [SLOTS];
    pstrr_pkg::req_t      req_reg;
    pstrr_pkg::req_t      req_next;
    logic [SLOTS-1:0]     upper_reg;
    logic [SLOTS-1:0]     upper_next;
    logic [SLOTS-1:0]     cand_reg;
    logic [SLOTS-1:0]     cand_next;
    logic                 valid_reg;
    logic                 valid_next;
    logic                 success_reg;
    logic                 success_next;
    logic [SW-1:0]        index_reg;
    logic [SW-1:0]        index_next;
    logic                 idle_reg;
    logic                 idle_next;

    logic [SLOTS-1:0]     run_vec;
    logic [SLOTS-1:0]     free_vec;
    logic [IDX_W-1:0]     start_idx;
    logic [IDX_W-1:0]     tgt_idx;
    logic [IDX_W-1:0]     free_idx;
    logic                 free_any;
    logic [IDX_W-1:0]     upper_idx;
    logic [IDX_W-1:0]     cand_idx;
    logic [IDX_W-1:0]     pick_idx;
    logic                 pick_any;

    always_comb
    begin
        for (int i = 0; i < SLOTS; i++)
        begin
            run_vec[i]  = (status_reg[i] == pstrr_pkg::ST_RUNNABLE);
            free_vec[i] = (status_reg[i] == pstrr_pkg::ST_UNUSED);
        end
    end

    assign start_idx = req_data.start[IDX_W-1:0];
    assign tgt_idx   = req_reg.slot[IDX_W-1:0];
    assign req_take  = (state_reg == S_WAIT) && req_valid && (!valid_reg || out_pop);

    // Lowest set bit of each search vector; the scan from the start slot
    // wraps to the lowest candidate when nothing lies at or above the start.
    always_comb
    begin
        free_idx  = '0;
        upper_idx = '0;
        cand_idx  = '0;
        for (int i = SLOTS - 1; i >= 0; i--)
        begin
            if (free_vec[i])
            begin
                free_idx = IDX_W'(i);
            end
            if (upper_reg[i])
            begin
                upper_idx = IDX_W'(i);
            end
            if (cand_reg[i])
            begin
                cand_idx = IDX_W'(i);
            end
        end
        free_any = |free_vec;
        pick_any = |cand_reg;
        pick_idx = (|upper_reg) ? upper_idx : cand_idx;
    end

    always_comb
    begin
        state_next   = state_reg;
        status_next  = status_reg;
        req_next     = req_reg;
        upper_next   = upper_reg;
        cand_next    = cand_reg;
        valid_next   = valid_reg;
        success_next = success_reg;
        index_next   = index_reg;
        idle_next    = idle_reg;

        if (out_pop)
        begin
            valid_next = 1'b0;
        end

        unique case (state_reg)
            S_WAIT:
            begin
                if (req_take)
                begin
                    req_next = req_data;
                    // Slot zero is never a scheduling candidate.
                    cand_next = run_vec & ~SLOTS'(1);
                    for (int i = 0; i < SLOTS; i++)
                    begin
                        upper_next[i] = run_vec[i] && (i != 0) && (IDX_W'(i) >= start_idx);
                    end
                    state_next = S_EVAL;
                end
            end
            S_EVAL:
            begin
                valid_next   = 1'b1;
                success_next = 1'b0;
                index_next   = '0;
                idle_next    = 1'b0;
                unique case (req_reg.op)
                    pstrr_pkg::OP_CREATE:
                    begin
                        if (free_any)
                        begin
                            status_next[free_idx] = pstrr_pkg::ST_RUNNABLE;
                            success_next = 1'b1;
                            index_next   = SW'(free_idx);
                        end
                    end
                    pstrr_pkg::OP_EXIT:
                    begin
                        if (req_reg.in_range)
                        begin
                            status_next[tgt_idx] = pstrr_pkg::ST_UNUSED;
                            success_next = 1'b1;
                            index_next   = req_reg.slot;
                        end
                    end
                    pstrr_pkg::OP_SET:
                    begin
                        if (req_reg.in_range)
                        begin
                            status_next[tgt_idx] = req_reg.new_status;
                            success_next = 1'b1;
                            index_next   = req_reg.slot;
                        end
                    end
                    pstrr_pkg::OP_SCHEDULE:
                    begin
                        // A terminated task in slot one forces the idle task.
                        if (pick_any && (status_reg[1] != pstrr_pkg::ST_TERMINATED))
                        begin
                            success_next = 1'b1;
                            index_next   = SW'(pick_idx);
                        end
                        else
                        begin
                            idle_next = 1'b1;
                        end
                    end
                    pstrr_pkg::OP_LOOKUP:
                    begin
                        if (req_reg.in_range && run_vec[tgt_idx])
                        begin
                            success_next = 1'b1;
                            index_next   = req_reg.slot;
                        end
                    end
                    default:
                    begin
                    end
                endcase
                state_next = S_WAIT;
            end
            default:
            begin
                state_next = S_WAIT;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_WAIT;
            valid_reg   <= 1'b0;
            success_reg <= 1'b0;
            index_reg   <= '0;
            idle_reg    <= 1'b0;
            for (int i = 0; i < SLOTS; i++)
            begin
                status_reg[i] <= pstrr_pkg::ST_UNUSED;
            end
        end
        else
        begin
            state_reg   <= state_next;
            valid_reg   <= valid_next;
            success_reg <= success_next;
            index_reg   <= index_next;
            idle_reg    <= idle_next;
            status_reg  <= status_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg   <= req_next;
        upper_reg <= upper_next;
        cand_reg  <= cand_next;
    end

    assign out_valid   = valid_reg;
    assign out_success = success_reg;
    assign out_index   = index_reg;
    assign out_idle    = idle_reg;

`ifndef ASSERT_OFF
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_EVAL) |-> !valid_reg)
        else $error("result register still full when a request completes");
    a_idle_excl: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg |-> !(success_reg && idle_reg))
        else $error("result reports both a pick and the idle task");
    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg && !success_reg) |-> (index_reg == '0))
        else $error("failed request carries a nonzero slot index");
    a_eval_once: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_EVAL) |=> (state_reg == S_WAIT) && valid_reg)
        else $error("request did not complete in one evaluation cycle");
`endif

endmodule

FILE: sv/process_slot_table_round_robin.sv
`timescale 1ns / 1ps
// A request passes through the request queue and then the back end's wait and
// evaluation states before its result shows on the result ports. The back end
// takes one request at a time, and none while an unpopped result is held.
// A two-entry request queue keeps accepting, until full, while a result waits.
// Reset (asynchronous, active low) marks every slot unused and empties the queue.
// ----------------------------------------------------------------------------
// Task slot table with round-robin scheduling
// Allocates, frees and updates task slots and picks the next runnable task.
// ----------------------------------------------------------------------------
module process_slot_table_round_robin #(
    parameter int SLOTS = pstrr_pkg::SLOTS_DEFAULT
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         push,
    output logic                         full,
    input  logic [2:0]                   command,
    input  logic [pstrr_pkg::SLOT_W-1:0] slot,
    input  logic [1:0]                   new_status,
    input  logic [pstrr_pkg::SLOT_W-1:0] current_slot,
    output logic                         empty,
    input  logic                         pop,
    output logic                         success,
    output logic [pstrr_pkg::SLOT_W-1:0] slot_index,
    output logic                         pick_idle
);

    pstrr_pkg::req_t front_req;
    pstrr_pkg::req_t queue_req;
    logic            queue_valid;
    logic            queue_take;
    logic            out_valid;

    pstrr_front #(
        .SLOTS (SLOTS)
    ) u_front (
        .command      (command),
        .slot         (slot),
        .new_status   (new_status),
        .current_slot (current_slot),
        .req          (front_req)
    );

    pstrr_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (push),
        .wr_data  (front_req),
        .is_full  (full),
        .rd_en    (queue_take),
        .rd_valid (queue_valid),
        .rd_data  (queue_req)
    );

    pstrr_back #(
        .SLOTS (SLOTS)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .req_valid   (queue_valid),
        .req_data    (queue_req),
        .req_take    (queue_take),
        .out_valid   (out_valid),
        .out_pop     (pop && out_valid),
        .out_success (success),
        .out_index   (slot_index),
        .out_idle    (pick_idle)
    );

    assign empty = !out_valid;

endmodule

FILE: test/process_slot_table_round_robin_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Slot table testbench
// Sends create, exit, set-status, schedule, lookup and reserved requests to
// the slot table with random gaps and result back-pressure. A local copy of
// the slot table predicts each result, and a checker compares every popped
// result field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module process_slot_table_round_robin_test;

    localparam int SLOT_W = pstrr_pkg::SLOT_W;
    localparam int SLOT_COUNT = pstrr_pkg::SLOTS_DEFAULT;
    localparam logic [2:0] CMD_RESERVED_FIRST = 3'd5;
    localparam logic [2:0] CMD_RESERVED_LAST = 3'd7;
    localparam logic [1:0] ST_OTHER = 2'd3;
    localparam logic [SLOT_W-1:0] SLOT_MAX = '1;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int LATENCY_SLACK = 10;
    localparam int MAX_REPORTS = 10;

    typedef struct packed {
        logic              success;
        logic [SLOT_W-1:0] slot_index;
        logic              pick_idle;
    } outcome_t;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              push = 1'b0;
    logic              full;
    logic [2:0]        command = pstrr_pkg::CMD_CREATE;
    logic [SLOT_W-1:0] slot = '0;
    logic [1:0]        new_status = pstrr_pkg::ST_UNUSED;
    logic [SLOT_W-1:0] current_slot = '0;
    logic              empty;
    logic              pop = 1'b0;
    logic              success;
    logic [SLOT_W-1:0] slot_index;
    logic              pick_idle;

    // Local copy of the slot table, advanced as each request is accepted.
    logic [1:0] table_status [SLOT_COUNT];
    outcome_t   pending_results [$];

    bit idling_on = 1'b1;
    int pop_hold = 0;
    int stall_cycles = 0;
    int error_count = 0;
    int requests_sent = 0;
    int results_checked = 0;
    int idle_picks = 0;
    int failed_creates = 0;

    process_slot_table_round_robin #(
        .SLOTS(SLOT_COUNT)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .push(push),
        .full(full),
        .command(command),
        .slot(slot),
        .new_status(new_status),
        .current_slot(current_slot),
        .empty(empty),
        .pop(pop),
        .success(success),
        .slot_index(slot_index),
        .pick_idle(pick_idle)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Updates the local slot table for one request and returns its result.
    function automatic outcome_t apply_request(input logic [2:0] cmd,
                                               input logic [SLOT_W-1:0] target,
                                               input logic [1:0] status_in,
                                               input logic [SLOT_W-1:0] running);
        outcome_t r;
        bit       in_range;
        int       pick;
        int       probe;
        r = '0;
        in_range = target < SLOT_COUNT;
        pick = -1;
        unique case (cmd)
            pstrr_pkg::CMD_CREATE:
            begin
                for (int i = 0; i < SLOT_COUNT; i++)
                begin
                    if (pick < 0 && table_status[i] == pstrr_pkg::ST_UNUSED)
                        pick = i;
                end
                if (pick >= 0)
                begin
                    table_status[pick] = pstrr_pkg::ST_RUNNABLE;
                    r.success = 1'b1;
                    r.slot_index = pick[SLOT_W-1:0];
                end
            end
            pstrr_pkg::CMD_EXIT, pstrr_pkg::CMD_SET:
            begin
                if (in_range)
                begin
                    table_status[target] = (cmd == pstrr_pkg::CMD_EXIT) ?
                                           pstrr_pkg::ST_UNUSED : status_in;
                    r.success = 1'b1;
                    r.slot_index = target;
                end
            end
            pstrr_pkg::CMD_SCHEDULE:
            begin
                // Slot zero is skipped; a terminated slot 1 forces the idle task.
                for (int i = 0; i < SLOT_COUNT; i++)
                begin
                    probe = (int'(running) + 1 + i) % SLOT_COUNT;
                    if (pick < 0 && probe != 0 &&
                        table_status[probe] == pstrr_pkg::ST_RUNNABLE)
                        pick = probe;
                end
                if (pick < 0 || table_status[1] == pstrr_pkg::ST_TERMINATED)
                    r.pick_idle = 1'b1;
                else
                begin
                    r.success = 1'b1;
                    r.slot_index = pick[SLOT_W-1:0];
                end
            end
            pstrr_pkg::CMD_LOOKUP:
            begin
                if (in_range && table_status[target] == pstrr_pkg::ST_RUNNABLE)
                begin
                    r.success = 1'b1;
                    r.slot_index = target;
                end
            end
            default:
            begin
            end
        endcase
        return r;
    endfunction

    function automatic logic [SLOT_W-1:0] random_slot();
        if ($urandom_range(0, 9) < 8)
            return SLOT_W'($urandom_range(0, SLOT_COUNT - 1));
        return SLOT_W'($urandom_range(0, 63));
    endfunction

    function automatic logic [2:0] random_command();
        int w;
        w = $urandom_range(0, 99);
        if (w < 20)
            return pstrr_pkg::CMD_CREATE;
        if (w < 35)
            return pstrr_pkg::CMD_EXIT;
        if (w < 55)
            return pstrr_pkg::CMD_SET;
        if (w < 80)
            return pstrr_pkg::CMD_SCHEDULE;
        if (w < 95)
            return pstrr_pkg::CMD_LOOKUP;
        return 3'($urandom_range(CMD_RESERVED_FIRST, CMD_RESERVED_LAST));
    endfunction

    // Called at a falling edge; returns at the falling edge after acceptance.
    task automatic send_request(input logic [2:0] cmd,
                                input logic [SLOT_W-1:0] target,
                                input logic [1:0] status_in,
                                input logic [SLOT_W-1:0] running);
        outcome_t r;
        if (idling_on && $urandom_range(0, 4) == 0)
        begin
            push <= 1'b0;
            repeat ($urandom_range(1, 19)) @(negedge clk);
        end
        push <= 1'b1;
        command <= cmd;
        slot <= target;
        new_status <= status_in;
        current_slot <= running;
        @(posedge clk);
        while (full)
            @(posedge clk);
        r = apply_request(cmd, target, status_in, running);
        pending_results.push_back(r);
        requests_sent++;
        if (r.pick_idle)
            idle_picks++;
        if (cmd == pstrr_pkg::CMD_CREATE && !r.success)
            failed_creates++;
        @(negedge clk);
    endtask

    task automatic wait_for_results();
        push <= 1'b0;
        while (pending_results.size() != 0)
            @(negedge clk);
    endtask

    task automatic note_failure(input string what, input outcome_t want, input outcome_t got);
        error_count++;
        if (error_count <= MAX_REPORTS)
        begin
            $write("ERROR %s: expected success=%0b slot_index=%0d pick_idle=%0b,",
                   what, want.success, want.slot_index, want.pick_idle);
            $display(" got success=%0b slot_index=%0d pick_idle=%0b",
                     got.success, got.slot_index, got.pick_idle);
        end
    endtask

    task automatic reset_block();
        for (int i = 0; i < SLOT_COUNT; i++)
            table_status[i] = pstrr_pkg::ST_UNUSED;
        rst_n <= 1'b0;
        repeat (5) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
    endtask

    task automatic test_directed_cases();
        send_request(pstrr_pkg::CMD_LOOKUP, '0, pstrr_pkg::ST_UNUSED, '0);
        send_request(pstrr_pkg::CMD_SCHEDULE, '0, pstrr_pkg::ST_UNUSED, '0);
        send_request(pstrr_pkg::CMD_CREATE, '0, pstrr_pkg::ST_UNUSED, '0);
        // Only slot zero is runnable here, and it must never be chosen.
        send_request(pstrr_pkg::CMD_SCHEDULE, '0, pstrr_pkg::ST_UNUSED, '0);
        for (int i = 1; i <= SLOT_COUNT; i++)
            send_request(pstrr_pkg::CMD_CREATE, '0, pstrr_pkg::ST_UNUSED, '0);
        send_request(pstrr_pkg::CMD_LOOKUP, SLOT_W'(SLOT_COUNT - 1), pstrr_pkg::ST_UNUSED, '0);
        send_request(pstrr_pkg::CMD_LOOKUP, SLOT_MAX, pstrr_pkg::ST_UNUSED, '0);
        send_request(pstrr_pkg::CMD_EXIT, SLOT_MAX, pstrr_pkg::ST_UNUSED, '0);
        send_request(pstrr_pkg::CMD_SET, SLOT_MAX, ST_OTHER, '0);
        send_request(pstrr_pkg::CMD_SCHEDULE, '0, pstrr_pkg::ST_UNUSED, SLOT_MAX);
        send_request(pstrr_pkg::CMD_SET, SLOT_W'(1), pstrr_pkg::ST_TERMINATED, '0);
        send_request(pstrr_pkg::CMD_SCHEDULE, '0, pstrr_pkg::ST_UNUSED, SLOT_W'(3));
        send_request(pstrr_pkg::CMD_SET, SLOT_W'(1), ST_OTHER, '0);
        send_request(pstrr_pkg::CMD_EXIT, SLOT_W'(SLOT_COUNT - 1), pstrr_pkg::ST_UNUSED, '0);
        send_request(pstrr_pkg::CMD_CREATE, '0, pstrr_pkg::ST_UNUSED, '0);
        for (logic [3:0] c = CMD_RESERVED_FIRST; c <= CMD_RESERVED_LAST; c++)
            send_request(c[2:0], SLOT_MAX, ST_OTHER, SLOT_MAX);
        send_request(pstrr_pkg::CMD_SCHEDULE, '0, pstrr_pkg::ST_UNUSED,
                     SLOT_W'(SLOT_COUNT - 2));
    endtask

    task automatic test_random_mix(input int count);
        for (int i = 0; i < count; i++)
            send_request(random_command(), random_slot(), 2'($urandom_range(0, 3)),
                         random_slot());
    endtask

    task automatic test_drain_pause();
        wait_for_results();
    endtask

    task automatic test_back_to_back(input int count);
        idling_on = 1'b0;
        test_random_mix(count);
    endtask

    // Result side: random pop stalls while idling is on.
    always @(negedge clk)
    begin
        if (pop_hold > 0)
        begin
            pop <= 1'b0;
            pop_hold <= pop_hold - 1;
        end
        else if (idling_on && rst_n && $urandom_range(0, 5) == 0)
        begin
            pop <= 1'b0;
            pop_hold <= $urandom_range(0, 18);
        end
        else
            pop <= 1'b1;
    end

    always @(posedge clk)
    begin
        outcome_t got;
        outcome_t want;
        if (rst_n && pop && !empty)
        begin
            got = '{success, slot_index, pick_idle};
            results_checked++;
            if (pending_results.size() == 0)
                note_failure("result with no request waiting", '0, got);
            else
            begin
                want = pending_results.pop_front();
                if (got.success !== want.success)
                    note_failure("success mismatch", want, got);
                else if (got.slot_index !== want.slot_index)
                    note_failure("slot_index mismatch", want, got);
                else if (got.pick_idle !== want.pick_idle)
                    note_failure("pick_idle mismatch", want, got);
            end
        end
    end

    // Ends the run if neither side makes progress for too long.
    always @(posedge clk)
    begin
        if ((push && !full) || (pop && !empty))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Watchdog expired after %0d cycles without progress.", WATCHDOG_LIMIT);
            $display("*** FAILED ***");
            $finish;
        end
    end

    initial
    begin
        reset_block();
        test_directed_cases();
        test_random_mix(600);
        test_drain_pause();
        test_random_mix(600);
        test_back_to_back(500);
        wait_for_results();
        repeat (LATENCY_SLACK) @(negedge clk);
        $display("Sent %0d requests of all commands, reserved codes and bad slots included.",
                 requests_sent);
        $display("Checked %0d results; %0d idle picks, %0d creates on a full table.",
                 results_checked, idle_picks, failed_creates);
        if (error_count == 0)
            $display("*** PASSED ***");
        else
        begin
            $display("%0d mismatches in total.", error_count);
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

FILE: files.f
sv/pstrr_pkg.sv
sv/pstrr_front.sv
sv/pstrr_queue.sv
sv/pstrr_back.sv
sv/process_slot_table_round_robin.sv
test/process_slot_table_round_robin_test.sv
